FILE: rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
package i2cm_pkg;

   localparam int CMD_QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [2:0] {
      OP_START      = 3'd0,
      OP_STOP       = 3'd1,
      OP_WRITE_BYTE = 3'd2,
      OP_READ_BYTE  = 3'd3,
      OP_SEND_ACK   = 3'd4,
      OP_READ_ACK   = 3'd5
   } op_type;

   typedef logic [1:0] phase_type;

   // Extra leading step of read byte that releases SDA before the bit loop.
   localparam phase_type PHASE_FIRST   = 2'd0;
   localparam phase_type PHASE_PRELUDE = 2'd3;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic [7:0] bus_bits;
      logic       bus_ack_level;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       is_sample;
      logic [7:0] rx_byte;
      logic       rx_ack;
      logic       last_event;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      phase_type  start_phase;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic [7:0] bus_bits;
      logic       bus_ack_level;
   } cmd_type;

endpackage

FILE: rtl/i2cm_front.sv
// Front end: accepts requests, drops unused opcodes, stages decoded commands.
module i2cm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  i2cm_pkg::req_type req_data,
   output logic              cmd_push,
   output i2cm_pkg::cmd_type cmd_data,
   input  logic              cmd_full
);
   import i2cm_pkg::*;

   logic    stage_valid_ff, stage_valid_in;
   cmd_type stage_ff, stage_in;
   logic    advance;
   logic    accept;
   logic    op_known;

   assign advance  = !stage_valid_ff || !cmd_full;
   assign accept   = req_push && advance;
   assign req_full = !advance;
   assign cmd_push = stage_valid_ff;
   assign cmd_data = stage_ff;

   always_comb begin
      unique case (req_data.opcode) inside
         OP_START, OP_STOP, OP_WRITE_BYTE, OP_READ_BYTE, OP_SEND_ACK, OP_READ_ACK: begin
            op_known = 1'b1;
         end
         default: begin
            op_known = 1'b0;
         end
      endcase
   end

   always_comb begin
      stage_in.op            = op_type'(req_data.opcode);
      stage_in.start_phase   = (req_data.opcode == OP_READ_BYTE) ? PHASE_PRELUDE : PHASE_FIRST;
      stage_in.tx_byte       = req_data.tx_byte;
      stage_in.ack_to_send   = req_data.ack_to_send;
      stage_in.bus_bits      = req_data.bus_bits;
      stage_in.bus_ack_level = req_data.bus_ack_level;
   end

   // drop unused opcodes: accepted, never queued
   assign stage_valid_in = advance ? (accept && op_known) : stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

FILE: rtl/i2cm_cmd_fifo.sv
// Short command queue between the front end and the line sequencer.
module i2cm_cmd_fifo #(
   parameter int DEPTH = i2cm_pkg::CMD_QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  i2cm_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output i2cm_pkg::cmd_type pop_data,
   output logic              empty
);
   import i2cm_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slots_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/i2cm_back.sv
// Back end: steps through command line events, one per cycle unless stalled.
module i2cm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  i2cm_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output i2cm_pkg::rsp_type rsp_data
);
   import i2cm_pkg::*;

   logic      busy_ff, busy_in;
   cmd_type   cmd_ff;
   phase_type phase_ff, phase_in;
   logic [2:0] bit_ff, bit_in;
   logic      scl_ff, scl_in;
   logic      sda_ff, sda_in;
   logic [7:0] rx_shift_ff, rx_shift_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_ff, event_in;

   logic      advance, step, load;
   logic      ev_set_scl, ev_set_sda, ev_level, ev_sample, ev_last;

   assign advance   = !out_valid_ff || rsp_pop;
   assign step      = busy_ff && advance;
   assign load      = !cmd_empty && (!busy_ff || (step && ev_last));
   assign cmd_pop   = load;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // event decode: which line moves, to what level, and whether the run ends
   always_comb begin
      ev_set_scl = 1'b0;
      ev_set_sda = 1'b0;
      ev_level   = 1'b0;
      ev_sample  = 1'b0;
      ev_last    = 1'b0;
      unique case (cmd_ff.op)
         OP_START: begin
            case (phase_ff)
               2'd0: begin ev_set_sda = 1'b1; ev_level = 1'b1; end
               2'd1: begin ev_set_scl = 1'b1; ev_level = 1'b1; end
               2'd2: begin ev_set_sda = 1'b1; ev_level = 1'b0; end
               default: begin ev_set_scl = 1'b1; ev_level = 1'b0; ev_last = 1'b1; end
            endcase
         end
         OP_STOP: begin
            case (phase_ff)
               2'd0: begin ev_set_sda = 1'b1; ev_level = 1'b0; end
               2'd1: begin ev_set_scl = 1'b1; ev_level = 1'b1; end
               default: begin ev_set_sda = 1'b1; ev_level = 1'b1; ev_last = 1'b1; end
            endcase
         end
         OP_WRITE_BYTE: begin
            case (phase_ff)
               2'd0: begin ev_set_sda = 1'b1; ev_level = cmd_ff.tx_byte[~bit_ff]; end
               2'd1: begin ev_set_scl = 1'b1; ev_level = 1'b1; end
               default: begin
                  ev_set_scl = 1'b1;
                  ev_level   = 1'b0;
                  ev_last    = (bit_ff == 3'd7);
               end
            endcase
         end
         OP_READ_BYTE: begin
            case (phase_ff)
               PHASE_PRELUDE: begin ev_set_sda = 1'b1; ev_level = 1'b1; end
               2'd0: begin ev_set_scl = 1'b1; ev_level = 1'b1; end
               2'd1: begin ev_sample = 1'b1; end
               default: begin
                  ev_set_scl = 1'b1;
                  ev_level   = 1'b0;
                  ev_last    = (bit_ff == 3'd7);
               end
            endcase
         end
         OP_SEND_ACK: begin
            case (phase_ff)
               2'd0: begin ev_set_sda = 1'b1; ev_level = cmd_ff.ack_to_send; end
               2'd1: begin ev_set_scl = 1'b1; ev_level = 1'b1; end
               default: begin ev_set_scl = 1'b1; ev_level = 1'b0; ev_last = 1'b1; end
            endcase
         end
         OP_READ_ACK: begin
            case (phase_ff)
               2'd0: begin ev_set_sda = 1'b1; ev_level = 1'b1; end
               2'd1: begin ev_set_scl = 1'b1; ev_level = 1'b1; end
               2'd2: begin ev_sample = 1'b1; end
               default: begin ev_set_scl = 1'b1; ev_level = 1'b0; ev_last = 1'b1; end
            endcase
         end
         default: begin
            ev_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      scl_in      = ev_set_scl ? ev_level : scl_ff;
      sda_in      = ev_set_sda ? ev_level : sda_ff;
      rx_shift_in = rx_shift_ff;
      if (cmd_ff.op == OP_READ_BYTE) begin
         if (phase_ff == PHASE_PRELUDE) begin
            rx_shift_in = '0;
         end else if (ev_sample) begin
            rx_shift_in = {rx_shift_ff[6:0], cmd_ff.bus_bits[~bit_ff]};
         end
      end

      event_in.scl_level  = scl_in;
      event_in.sda_level  = sda_in;
      event_in.is_sample  = ev_sample;
      event_in.rx_byte    = (cmd_ff.op == OP_READ_BYTE && ev_last) ? rx_shift_ff : 8'd0;
      event_in.rx_ack     = (cmd_ff.op == OP_READ_ACK && ev_last) ? cmd_ff.bus_ack_level
                                                                 : 1'b0;
      event_in.last_event = ev_last;
   end

   // advance the step counters; byte commands loop over three phases per bit
   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      if ((cmd_ff.op == OP_WRITE_BYTE || cmd_ff.op == OP_READ_BYTE) && phase_ff == 2'd2) begin
         phase_in = PHASE_FIRST;
         bit_in   = bit_ff + 1'b1;
      end else if (phase_ff == PHASE_PRELUDE) begin
         phase_in = PHASE_FIRST;
      end else begin
         phase_in = phase_ff + 1'b1;
      end
   end

   always_comb begin
      if (load) begin
         busy_in = 1'b1;
      end else if (step && ev_last) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
      out_valid_in = advance ? busy_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rx_shift_ff  <= '0;
         phase_ff     <= PHASE_FIRST;
         bit_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            scl_ff      <= scl_in;
            sda_ff      <= sda_in;
            rx_shift_ff <= rx_shift_in;
         end
         if (load) begin
            phase_ff <= cmd_data.start_phase;
            bit_ff   <= '0;
         end else if (step) begin
            phase_ff <= phase_in;
            bit_ff   <= bit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= cmd_data;
      end
      if (step) begin
         out_ff <= event_in;
      end
   end

endmodule

FILE: rtl/i2c_master_bit_sequencer_core.sv
// Top level of the I2C master bit sequencer: front end, command queue, line sequencer.
//
//   channel  direction  handshake                 payload
//   req_     in         req_push / req_full       i2cm_pkg::req_type
//   rsp_     out        rsp_empty / rsp_pop       i2cm_pkg::rsp_type
//
// Each command yields one line event per cycle unless the output is stalled: start 4,
// stop 3, write byte 24, read byte 25, send ack 3, read ack 4. The sequencer's event
// step sets the rate; the next queued command loads on the previous one's last event.
// A request is registered in the front stage before it is queued.
// Reset leaves SCL and SDA high, the queue and the output register empty.
// Holding rsp_pop low while a response waits stalls the sequencer; the queue lets requests arrive meanwhile.
module i2c_master_bit_sequencer_core #(
   parameter int CMD_QUEUE_DEPTH = i2cm_pkg::CMD_QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  i2cm_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output i2cm_pkg::rsp_type rsp_data
);
   import i2cm_pkg::*;

   logic    fq_push, fq_full, fq_pop, fq_empty;
   cmd_type fq_push_data, fq_pop_data;

   i2cm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_push (fq_push),
      .cmd_data (fq_push_data),
      .cmd_full (fq_full)
   );

   i2cm_cmd_fifo #(
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_push_data),
      .full      (fq_full),
      .pop       (fq_pop),
      .pop_data  (fq_pop_data),
      .empty     (fq_empty)
   );

   i2cm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (fq_empty),
      .cmd_data  (fq_pop_data),
      .cmd_pop   (fq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      fq_pop |-> !fq_empty)
      else $error("sequencer took a command from an empty queue");

   a_sample_scl_high: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.is_sample) |-> rsp_data.scl_level)
      else $error("sample point with SCL low");

   a_rx_only_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.last_event) |->
         (rsp_data.rx_byte == 8'd0 && rsp_data.rx_ack == 1'b0))
      else $error("received data shown before the last event");

   a_run_end_levels: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.last_event) |->
         (!rsp_data.scl_level || rsp_data.sda_level))
      else $error("run ended with SCL high and SDA low");
`endif

endmodule
